/* rtl/srbd_pkg.sv */
// Package for the snapshot RLE block decoder.
// Holds field widths, the escape byte, phase states and the run descriptor types.
// No dependencies.
`timescale 1ns / 1ps

package srbd_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 8;
    localparam int POS_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [BYTE_W-1:0] ESC_BYTE      = 8'hED;
    localparam logic              MODE_RESET    = 1'b1;
    localparam logic [POS_W-1:0]  LIMIT_RESET   = 16'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMPRESSED_MODE = 1'b0,
        CFG_OUTPUT_LIMIT    = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_ONE   = 2'd1,
        ESC_TWO   = 2'd2,
        ESC_COUNT = 2'd3
    } t_esc_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [LEN_W-1:0]  length;
        logic [POS_W-1:0]  offset;
        logic              finished;
    } t_run;

    typedef struct packed {
        t_run r0;
        t_run r1;
        logic two;
    } t_entry;

endpackage

/* rtl/srbd_if.sv */
// Channel interfaces of the snapshot RLE block decoder: byte input, run output, config write.
// Depends on srbd_pkg for widths.
`timescale 1ns / 1ps

interface srbd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [srbd_pkg::BYTE_W-1:0] in_byte;
    logic                       is_last;
    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface srbd_run_if;
    logic                        valid;
    logic                        ready;
    logic [srbd_pkg::BYTE_W-1:0] run_value;
    logic [srbd_pkg::LEN_W-1:0]  run_length;
    logic [srbd_pkg::POS_W-1:0]  run_offset;
    logic                        finished;
    modport source (output valid, output run_value, output run_length, output run_offset,
                    output finished, input ready);
    modport sink   (input valid, input run_value, input run_length, input run_offset,
                    input finished, output ready);
endinterface

interface srbd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [srbd_pkg::CFG_IDX_W-1:0]  index;
    logic [srbd_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/srbd_front.sv */
// Front part: config registers, escape phase tracking and run classification.
// Produces at most one queue entry of up to two runs per accepted byte. Depends on srbd_pkg.
`timescale 1ns / 1ps

module srbd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_is_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [0:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    output logic                  o_push,
    output srbd_pkg::t_entry      o_entry,
    input  logic                  i_queue_full
);
    import srbd_pkg::*;

    logic             r_mode;
    logic [POS_W-1:0] r_limit;
    t_esc_phase       r_phase, n_phase;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0] r_pos, n_pos;

    logic             accept;
    logic             lim_hit;
    logic [POS_W-1:0] pos1;
    logic [POS_W-1:0] room;
    logic [LEN_W-1:0] len3;
    logic             is_esc;
    logic [1:0]       nres;
    t_entry           ent;

    assign o_ready     = !i_queue_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign is_esc      = (i_in_byte == ESC_BYTE);
    assign lim_hit     = (r_pos >= r_limit);
    assign pos1        = r_pos + POS_W'(1);
    assign room        = r_limit - r_pos;
    assign len3        = ({{(POS_W-LEN_W){1'b0}}, r_cnt} < room) ? r_cnt : room[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COMPRESSED_MODE: r_mode  <= i_cfg_data[0];
                CFG_OUTPUT_LIMIT:    r_limit <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ESC_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        ent     = '0;
        nres    = 2'd0;
        ent.r0.offset = r_pos;
        ent.r1.offset = pos1;
        if (accept) begin
            if (lim_hit) begin
                n_phase = ESC_IDLE;
                n_cnt   = '0;
            end else if (!r_mode) begin
                n_phase = ESC_IDLE;
                n_cnt   = '0;
                ent.r0.value  = i_in_byte;
                ent.r0.length = LEN_W'(1);
                nres = 2'd1;
            end else begin
                unique case (r_phase)
                    ESC_IDLE: begin
                        if (is_esc && !i_is_last) begin
                            n_phase = ESC_ONE;
                        end else begin
                            ent.r0.value  = i_in_byte;
                            ent.r0.length = LEN_W'(1);
                            nres = 2'd1;
                        end
                    end
                    ESC_ONE: begin
                        if (is_esc) begin
                            n_phase = i_is_last ? ESC_IDLE : ESC_TWO;
                        end else begin
                            n_phase = ESC_IDLE;
                            ent.r0.value  = ESC_BYTE;
                            ent.r0.length = LEN_W'(1);
                            nres = 2'd1;
                            if (pos1 < r_limit) begin
                                ent.r1.value  = i_in_byte;
                                ent.r1.length = LEN_W'(1);
                                ent.two = 1'b1;
                                nres = 2'd2;
                            end
                        end
                    end
                    ESC_TWO: begin
                        if (i_is_last) begin
                            n_phase = ESC_IDLE;
                        end else begin
                            n_cnt   = i_in_byte;
                            n_phase = ESC_COUNT;
                        end
                    end
                    ESC_COUNT: begin
                        n_phase = ESC_IDLE;
                        n_cnt   = '0;
                        if (len3 != '0) begin
                            ent.r0.value  = i_in_byte;
                            ent.r0.length = len3;
                            nres = 2'd1;
                        end
                    end
                    default: n_phase = ESC_IDLE;
                endcase
            end
            n_pos = r_pos + {{(POS_W-LEN_W){1'b0}}, ent.r0.length}
                          + {{(POS_W-1){1'b0}}, ent.two};
            if (i_is_last) begin
                if (nres == 2'd0) begin
                    nres = 2'd1;
                end
                if (ent.two) begin
                    ent.r1.finished = 1'b1;
                end else begin
                    ent.r0.finished = 1'b1;
                end
                n_phase = ESC_IDLE;
                n_cnt   = '0;
                n_pos   = '0;
            end
        end
    end

    assign o_push  = accept && (nres != 2'd0);
    assign o_entry = ent;

endmodule

/* rtl/srbd_queue.sv */
// Short queue of run entries between front and back parts.
// Depth set by parameter. Depends on srbd_pkg for the entry type.
`timescale 1ns / 1ps

module srbd_queue #(
    parameter int DEPTH = srbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  srbd_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output srbd_pkg::t_entry o_entry
);
    import srbd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

/* rtl/srbd_back.sv */
// Back part: holds one queue entry and delivers its runs one per cycle while i_ready is high.
// Drives the registered run output. Depends on srbd_pkg.
`timescale 1ns / 1ps

module srbd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  srbd_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output srbd_pkg::t_run   o_run
);
    import srbd_pkg::*;

    t_entry r_ent;
    logic   r_busy;
    logic   r_sel;
    logic   taken;
    logic   done;

    assign o_valid = r_busy;
    assign o_run   = r_sel ? r_ent.r1 : r_ent.r0;
    assign taken   = r_busy && i_ready;
    assign done    = taken && (r_sel || !r_ent.two);
    assign o_pop   = !r_busy || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sel  <= 1'b0;
        end else if (o_pop && i_valid) begin
            r_busy <= 1'b1;
            r_sel  <= 1'b0;
        end else if (done) begin
            r_busy <= 1'b0;
            r_sel  <= 1'b0;
        end else if (taken) begin
            r_sel  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_valid) begin
            r_ent <= i_entry;
        end
    end

endmodule

/* rtl/snapshot_rle_block_decoder_unit.sv */
// Top level of the snapshot RLE block decoder: front, queue and back parts.
// Depends on srbd_pkg, srbd_if, srbd_front, srbd_queue, srbd_back.
//
//   channel  dir  fields                                        handshake
//   i_byte   in   in_byte[7:0], is_last                         valid/ready
//   o_run    out  run_value[7:0], run_length[7:0],
//                 run_offset[15:0], finished                    valid/ready
//   i_cfg    in   index[0] (0 mode, 1 limit), data[15:0]        valid/ready
//
// One byte per cycle enters while the queue has room; the front decides its
// runs in that cycle. The back sends one run per cycle while o_run is ready,
// so a lone ED that yields two runs sends them in turn. A run is registered in
// the queue, then the back. Sync active-low reset; config writes always accepted.
`timescale 1ns / 1ps

module snapshot_rle_block_decoder_unit #(
    parameter int QUEUE_DEPTH = srbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srbd_byte_if.sink   i_byte,
    srbd_cfg_if.sink    i_cfg,
    srbd_run_if.source  o_run
);
    import srbd_pkg::*;

    logic   push, full, q_valid, pop;
    t_entry f_entry, q_entry;
    t_run   run;

    srbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_byte.valid),
        .o_ready      (i_byte.ready),
        .i_in_byte    (i_byte.in_byte),
        .i_is_last    (i_byte.is_last),
        .i_cfg_valid  (i_cfg.valid),
        .o_cfg_ready  (i_cfg.ready),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_push       (push),
        .o_entry      (f_entry),
        .i_queue_full (full)
    );

    srbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    srbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_pop   (pop),
        .o_valid (o_run.valid),
        .i_ready (o_run.ready),
        .o_run   (run)
    );

    assign o_run.run_value  = run.value;
    assign o_run.run_length = run.length;
    assign o_run.run_offset = run.offset;
    assign o_run.finished   = run.finished;

endmodule
